// File: sv/lpht_pkg.sv
// package: types, codes and constants of the linear probing hash table
package lpht_pkg;

   localparam int unsigned TableDepth = 1024;
   localparam int unsigned SizeWidth  = 11;
   localparam logic [31:0] MixConst   = 32'h045d9f3b;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_LOOKUP = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MIX1,
      S_MUL1,
      S_MIX2,
      S_MUL2,
      S_MIX3,
      S_MOD,
      S_READ,
      S_WAIT,
      S_CHECK,
      S_DONE
   } state_type;

endpackage

// File: sv/lpht_ram.sv
// generic single-port ram with registered read
module lpht_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// File: sv/linear_probe_hash_table.sv
// linear probing hash table: hash sequencer, probe walk and slot stores
// flow: hash (mix, multiply, mix, multiply, mix), modulo reduction, then read, wait, check per probed slot, then output
// one transaction at a time; a miss or a full insert walks all active slots
// a clearing pass after reset walks every slot and clears the used marks; no input meanwhile
// the modulo is a restoring shift-subtract over the 32-bit hash, one step per cycle
// reset: synchronous, active high; size_reg_ff returns to 1024
module linear_probe_hash_table #(
   parameter int unsigned TABLE_DEPTH = lpht_pkg::TableDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // func[1:0], key[33:2], payload[65:34], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata   // status[1:0], found_payload[33:2], slot_index[43:34], zero
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = AW + 1;

   lpht_pkg::state_type state_ff, state_in;
   logic [10:0]   size_reg_ff;
   logic [CW-1:0] size_ff, size_in;
   logic [1:0]    func_ff, func_in;
   logic [31:0]   key_ff, key_in, pay_ff, pay_in, h_ff, h_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [5:0]    bit_ff, bit_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    st_ff, st_in;
   logic [31:0]   dat_ff, dat_in;
   logic [AW-1:0] slot_ff, slot_in;

   logic          used_we, used_wd, used_rd;
   logic          kp_we;
   logic [31:0]   key_rd, pay_rd;
   logic [CW:0]   rem_sh, rem_sub;
   logic [AW-1:0] idx_next;
   logic [CW-1:0] act_size;
   logic [63:0]   prod;

   lpht_ram #(.Width(1), .Depth(TABLE_DEPTH)) u_used (
      .clock(clock), .wr_en(used_we), .addr(idx_ff), .wr_data(used_wd), .rd_data(used_rd));
   lpht_ram #(.Width(32), .Depth(TABLE_DEPTH)) u_key (
      .clock(clock), .wr_en(kp_we), .addr(idx_ff), .wr_data(key_ff), .rd_data(key_rd));
   lpht_ram #(.Width(32), .Depth(TABLE_DEPTH)) u_pay (
      .clock(clock), .wr_en(kp_we), .addr(idx_ff), .wr_data(pay_ff), .rd_data(pay_rd));

   always_comb begin
      if (size_reg_ff == 11'd0) begin
         act_size = CW'(1);
      end else if ({21'd0, size_reg_ff} > 32'(TABLE_DEPTH)) begin
         act_size = CW'(TABLE_DEPTH);
      end else begin
         act_size = CW'(size_reg_ff);
      end
   end

   assign prod     = 64'(h_ff) * 64'(lpht_pkg::MixConst);
   assign rem_sh   = {rem_ff, h_ff[31]};
   assign rem_sub  = rem_sh - {1'b0, size_ff};
   assign idx_next = ({1'b0, idx_ff} + CW'(1) == size_ff) ? '0 : AW'(idx_ff + AW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lpht_pkg::S_CLEAR;
         size_reg_ff <= 11'd1024;
         idx_ff      <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr_wr_en) begin
            size_reg_ff <= csr_wr_data;
         end
      end
      size_ff <= size_in;
      func_ff <= func_in;
      key_ff  <= key_in;
      pay_ff  <= pay_in;
      h_ff    <= h_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
      st_ff   <= st_in;
      dat_ff  <= dat_in;
      slot_ff <= slot_in;
   end

   always_comb begin
      state_in = state_ff;
      size_in  = size_ff;
      func_in  = func_ff;
      key_in   = key_ff;
      pay_in   = pay_ff;
      h_in     = h_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      st_in    = st_ff;
      dat_in   = dat_ff;
      slot_in  = slot_ff;
      used_we  = 1'b0;
      used_wd  = 1'b0;
      kp_we    = 1'b0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         lpht_pkg::S_CLEAR: begin
            used_we = 1'b1;
            idx_in  = AW'(idx_ff + AW'(1));
            if (idx_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = lpht_pkg::S_IDLE;
            end
         end
         lpht_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in  = req_tdata[1:0];
               key_in   = req_tdata[33:2];
               pay_in   = req_tdata[65:34];
               h_in     = req_tdata[33:2];
               size_in  = act_size;
               st_in    = lpht_pkg::ST_MISSING;
               dat_in   = '0;
               slot_in  = '0;
               state_in = (req_tdata[1:0] == lpht_pkg::FUNC_NONE) ?
                          lpht_pkg::S_DONE : lpht_pkg::S_MIX1;
            end
         end
         lpht_pkg::S_MIX1: begin
            h_in = h_ff ^ (h_ff >> 16);
            state_in = lpht_pkg::S_MUL1;
         end
         lpht_pkg::S_MUL1: begin
            h_in = prod[31:0];
            state_in = lpht_pkg::S_MIX2;
         end
         lpht_pkg::S_MIX2: begin
            h_in = h_ff ^ (h_ff >> 16);
            state_in = lpht_pkg::S_MUL2;
         end
         lpht_pkg::S_MUL2: begin
            h_in = prod[31:0];
            state_in = lpht_pkg::S_MIX3;
         end
         lpht_pkg::S_MIX3: begin
            h_in   = h_ff ^ (h_ff >> 16);
            rem_in = '0;
            bit_in = '0;
            state_in = lpht_pkg::S_MOD;
         end
         lpht_pkg::S_MOD: begin
            // restoring division step, quotient discarded
            h_in = {h_ff[30:0], 1'b0};
            rem_in = rem_sub[CW] ? CW'(rem_sh) : CW'(rem_sub);
            bit_in = bit_ff + 6'd1;
            if (bit_ff == 6'd31) begin
               state_in = lpht_pkg::S_READ;
               cnt_in   = '0;
               st_in    = (func_ff == lpht_pkg::FUNC_INSERT) ?
                          lpht_pkg::ST_FULL : lpht_pkg::ST_MISSING;
            end
         end
         lpht_pkg::S_READ: begin
            if (bit_ff == 6'd32) begin
               idx_in = AW'(rem_ff);
               bit_in = '0;
            end
            state_in = lpht_pkg::S_WAIT;
         end
         lpht_pkg::S_WAIT: begin
            state_in = lpht_pkg::S_CHECK;
         end
         lpht_pkg::S_CHECK: begin
            state_in = lpht_pkg::S_READ;
            if (func_ff == lpht_pkg::FUNC_INSERT) begin
               if (!used_rd) begin
                  used_we = 1'b1;
                  used_wd = 1'b1;
                  kp_we   = 1'b1;
                  st_in   = lpht_pkg::ST_OK;
                  slot_in = idx_ff;
                  state_in = lpht_pkg::S_DONE;
               end
            end else if (used_rd && key_rd == key_ff) begin
               st_in   = lpht_pkg::ST_OK;
               slot_in = idx_ff;
               if (func_ff == lpht_pkg::FUNC_LOOKUP) begin
                  dat_in = pay_rd;
               end else begin
                  used_we = 1'b1;
               end
               state_in = lpht_pkg::S_DONE;
            end
            if (state_in == lpht_pkg::S_READ) begin
               cnt_in = cnt_ff + CW'(1);
               idx_in = idx_next;
               if (cnt_ff + CW'(1) == size_ff) begin
                  state_in = lpht_pkg::S_DONE;
               end
            end
         end
         lpht_pkg::S_DONE: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = lpht_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lpht_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_tdata = {28'd0, 10'(slot_ff), dat_ff, st_ff};

endmodule
